/* rtl/ffa_pkg.sv */
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int HDR_SHIFT    = $clog2(HEADER_BYTES);
  localparam int SLOT_COUNT   = HEAP_BYTES / HEADER_BYTES;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);

  localparam int FUNC_W = 2;
  localparam int PTR_W  = 32;
  localparam int REQ_W  = 16;
  localparam int SIZE_W = 17;
  localparam int STAT_W = 2;

  // wide enough for last slot + 1 + last size / 16 + 1 + new size / 16
  localparam int BUMP_W = ((SLOT_W > SIZE_W - HDR_SHIFT) ? SLOT_W : SIZE_W - HDR_SHIFT) + 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int CFG_IDXW = CFG_AW - 2;
  localparam logic [CFG_IDXW-1:0] REG_HEAP_BASE = '0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REALLOC = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK  = 2'd0,
    STAT_OOM = 2'd1,
    STAT_BAD = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_BAD,
    OP_ALLOC,
    OP_FREE,
    OP_REALLOC
  } op_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RESOLVE,
    S_WALK,
    S_BUMP,
    S_FINISH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic              mark;
    logic              next_null;
    logic [SIZE_W-1:0] size;
    logic [SLOT_W-1:0] next;
  } hdr_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [PTR_W-1:0]  pointer;
    logic [REQ_W-1:0]  req;
    logic [SIZE_W-1:0] nsize;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

endpackage

/* rtl/ffa_front.sv */
`timescale 1ns / 1ps
module ffa_front (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ffa_pkg::IN_TDATA_W-1:0]   in_data,
  input  logic [ffa_pkg::FUNC_W-1:0]       in_user,
  input  logic [ffa_pkg::PTR_W-1:0]        heap_base,
  input  logic                             enable,
  output logic                             push_valid,
  input  logic                             push_ready,
  output ffa_pkg::cmd_t                    push_cmd
);
  import ffa_pkg::*;

  logic [PTR_W-1:0] pointer;
  logic [REQ_W-1:0] req;
  logic [PTR_W-1:0] off;
  logic             ptr_ok;
  logic             ptr_null;
  op_kind_t         kind;

  assign pointer  = in_data[PTR_W-1:0];
  assign req      = in_data[PTR_W+REQ_W-1:PTR_W];
  assign ptr_null = (pointer == '0);

  // offset must be slot aligned, past the first slot and inside the heap
  assign off    = pointer - heap_base;
  assign ptr_ok = (off[HDR_SHIFT-1:0] == '0) &&
                  (off >= PTR_W'(HEADER_BYTES)) &&
                  (off < PTR_W'(HEAP_BYTES));

  always_comb begin
    unique case (in_user)
      FUNC_ALLOC:   kind = OP_ALLOC;
      FUNC_FREE:    kind = ptr_null ? OP_NONE : (ptr_ok ? OP_FREE : OP_BAD);
      FUNC_REALLOC: kind = ptr_null ? OP_ALLOC : (ptr_ok ? OP_REALLOC : OP_BAD);
      default:      kind = OP_NONE;
    endcase
  end

  always_comb begin
    push_cmd.kind    = kind;
    push_cmd.pointer = pointer;
    push_cmd.req     = req;
    push_cmd.nsize   = SIZE_W'({req[REQ_W-1:HDR_SHIFT], {HDR_SHIFT{1'b0}}}) +
                       SIZE_W'(HEADER_BYTES);
    push_cmd.slot    = off[SLOT_W+HDR_SHIFT-1:HDR_SHIFT] - SLOT_W'(1);
  end

  assign push_valid = in_valid && enable;
  assign in_ready   = push_ready && enable;

endmodule

/* rtl/ffa_cmd_fifo.sv */
`timescale 1ns / 1ps
module ffa_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s_valid,
  output logic           s_ready,
  input  ffa_pkg::cmd_t  s_cmd,
  output logic           m_valid,
  input  logic           m_ready,
  output ffa_pkg::cmd_t  m_cmd
);
  import ffa_pkg::*;

  cmd_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               push;
  logic               pop;

  assign s_ready = (count_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign m_valid = (count_r != '0);
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;
  assign m_cmd   = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= s_cmd;
    end
  end

endmodule

/* rtl/ffa_back.sv */
`timescale 1ns / 1ps
module ffa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ffa_pkg::PTR_W-1:0]   heap_base,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  ffa_pkg::cmd_t               q_cmd,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ffa_pkg::STAT_W-1:0]  out_status,
  output logic [ffa_pkg::PTR_W-1:0]   out_address,
  output logic [ffa_pkg::SIZE_W-1:0]  out_copy
);
  import ffa_pkg::*;

  state_t state_r, state_nxt;

  hdr_t hdr_mem [SLOT_COUNT];
  hdr_t rd_data_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  hdr_t              wr_data;

  logic [SLOT_W-1:0] clr_idx_r;
  logic [SLOT_W-1:0] free_head_r;
  logic              free_empty_r;
  logic [SLOT_W-1:0] last_slot_r;
  logic [SIZE_W-1:0] last_size_r;

  cmd_t              cmd_r;
  hdr_t              old_ent_r;
  hdr_t              prev_ent_r;
  logic [SLOT_W-1:0] node_r;
  logic [SLOT_W-1:0] prev_r;
  logic [SLOT_W-1:0] steps_r;
  logic [SLOT_W-1:0] grant_r;
  status_t           res_status_r;
  logic [PTR_W-1:0]  res_addr_r;
  logic [SIZE_W-1:0] res_copy_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [PTR_W-1:0]  out_addr_r;
  logic [SIZE_W-1:0] out_copy_r;

  logic              fits;
  logic              at_head;
  logic              walk_end;
  logic              old_fits;
  logic              is_realloc;
  logic [BUMP_W-1:0] nslot;
  logic [BUMP_W-1:0] nend;
  logic              oom;
  logic              res_load;
  logic [PTR_W-1:0]  grant_addr;

  assign fits       = (rd_data_r.size >= SIZE_W'(cmd_r.req));
  assign at_head    = (node_r == free_head_r);
  assign walk_end   = rd_data_r.next_null || (steps_r == SLOT_W'(SLOT_COUNT - 1));
  assign old_fits   = (rd_data_r.size >= SIZE_W'(cmd_r.req));
  assign is_realloc = (cmd_r.kind == OP_REALLOC);
  assign nslot      = BUMP_W'(last_slot_r) + BUMP_W'(1) +
                      BUMP_W'(last_size_r[SIZE_W-1:HDR_SHIFT]);
  assign nend       = nslot + BUMP_W'(1) + BUMP_W'(cmd_r.nsize[SIZE_W-1:HDR_SHIFT]);
  assign oom        = (nend > BUMP_W'(SLOT_COUNT));
  assign grant_addr = heap_base + ((PTR_W'(grant_r) + PTR_W'(1)) << HDR_SHIFT);
  assign res_load   = (state_r == S_RESULT) && (!out_valid_r || out_ready);
  assign clearing   = (state_r == S_CLEAR);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == SLOT_W'(SLOT_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            OP_FREE, OP_REALLOC: state_nxt = S_RESOLVE;
            OP_ALLOC:            state_nxt = free_empty_r ? S_BUMP : S_WALK;
            default:             state_nxt = S_RESULT;
          endcase
        end
      end
      S_RESOLVE: begin
        if (!rd_data_r.mark || !is_realloc || old_fits) begin
          state_nxt = S_RESULT;
        end else begin
          state_nxt = free_empty_r ? S_BUMP : S_WALK;
        end
      end
      S_WALK: begin
        if (fits) begin
          state_nxt = S_FINISH;
        end else if (walk_end) begin
          state_nxt = S_BUMP;
        end
      end
      S_BUMP:   state_nxt = oom ? S_RESULT : S_FINISH;
      S_FINISH: state_nxt = S_RESULT;
      S_RESULT: begin
        if (res_load) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // memory and queue controls
  always_comb begin
    q_pop   = 1'b0;
    rd_addr = free_head_r;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
      end
      S_IDLE: begin
        q_pop   = q_valid;
        rd_addr = (q_cmd.kind == OP_ALLOC) ? free_head_r : q_cmd.slot;
      end
      S_RESOLVE: begin
        // a free pushes the block on the list head, keeping mark and size
        if (rd_data_r.mark && !is_realloc) begin
          wr_en             = 1'b1;
          wr_addr           = cmd_r.slot;
          wr_data           = rd_data_r;
          wr_data.next      = free_head_r;
          wr_data.next_null = free_empty_r;
        end
      end
      S_WALK: begin
        rd_addr = rd_data_r.next;
        // unlink from the middle of the list
        if (fits && !at_head) begin
          wr_en             = 1'b1;
          wr_addr           = prev_r;
          wr_data           = prev_ent_r;
          wr_data.next      = rd_data_r.next;
          wr_data.next_null = rd_data_r.next_null;
        end
      end
      S_BUMP: begin
        if (!oom) begin
          wr_en             = 1'b1;
          wr_addr           = nslot[SLOT_W-1:0];
          wr_data.mark      = 1'b1;
          wr_data.next_null = 1'b1;
          wr_data.size      = cmd_r.nsize;
          wr_data.next      = '0;
        end
      end
      S_FINISH: begin
        // a moving realloc frees the old block after the grant
        if (is_realloc) begin
          wr_en             = 1'b1;
          wr_addr           = cmd_r.slot;
          wr_data           = old_ent_r;
          wr_data.next      = free_head_r;
          wr_data.next_null = free_empty_r;
        end
      end
      S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= hdr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      free_head_r  <= '0;
      free_empty_r <= 1'b1;
      last_slot_r  <= '0;
      last_size_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + SLOT_W'(1);
      end
      if (state_r == S_RESOLVE && rd_data_r.mark && !is_realloc) begin
        free_head_r  <= cmd_r.slot;
        free_empty_r <= 1'b0;
      end
      if (state_r == S_WALK && fits && at_head) begin
        free_head_r  <= rd_data_r.next;
        free_empty_r <= rd_data_r.next_null;
      end
      if (state_r == S_BUMP && !oom) begin
        last_slot_r <= nslot[SLOT_W-1:0];
        last_size_r <= cmd_r.nsize;
      end
      if (state_r == S_FINISH && is_realloc) begin
        free_head_r  <= cmd_r.slot;
        free_empty_r <= 1'b0;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cmd_r        <= q_cmd;
          node_r       <= free_head_r;
          steps_r      <= '0;
          res_status_r <= (q_cmd.kind == OP_BAD) ? STAT_BAD : STAT_OK;
          res_addr_r   <= '0;
          res_copy_r   <= '0;
        end
      end
      S_RESOLVE: begin
        old_ent_r <= rd_data_r;
        node_r    <= free_head_r;
        steps_r   <= '0;
        if (!rd_data_r.mark) begin
          res_status_r <= STAT_BAD;
        end else if (is_realloc && old_fits) begin
          res_addr_r <= cmd_r.pointer;
        end
      end
      S_WALK: begin
        if (fits) begin
          grant_r <= node_r;
        end else begin
          prev_r     <= node_r;
          prev_ent_r <= rd_data_r;
          node_r     <= rd_data_r.next;
          steps_r    <= steps_r + SLOT_W'(1);
        end
      end
      S_BUMP: begin
        if (oom) begin
          res_status_r <= STAT_OOM;
        end else begin
          grant_r <= nslot[SLOT_W-1:0];
        end
      end
      S_FINISH: begin
        res_addr_r <= grant_addr;
        if (is_realloc) begin
          res_copy_r <= old_ent_r.size;
        end
      end
      default: begin
      end
    endcase
    if (res_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_copy_r   <= res_copy_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_addr_r;
  assign out_copy    = out_copy_r;

endmodule

/* rtl/first_fit_free_list_allocator.sv */
`timescale 1ns / 1ps
// first-fit heap allocator over 16-byte slots, each block led by a header slot
// in_ stream: one command per beat, func in tuser, pointer and size in tdata
// out_ stream: one result beat per command, status in tuser, address and
//   copy length in tdata; results come back in command order
// cfg_ port: register heap_base at byte address 0, written while idle
// paths: a command enters a two-entry queue when accepted; the back end then
//   goes from idle straight to its result state for a null free, func 3 or
//   a misaligned or out-of-range pointer, through resolve for a free, an
//   in-place realloc or an unmarked pointer, and through bump and finish for
//   an allocate on an empty free list; a walk reads free-list nodes until one
//   fits or the list ends, an out-of-memory answer skips finish, and a moving
//   realloc passes through resolve for its header lookup first
// throughput: one command at a time in the back end, whose header memory has
//   one read and one write port (one header read per cycle on the free-list walk)
// reset: heap_base, free list and bump pointer clear at once; the header
//   memory is then cleared one slot a cycle, while in_tready
//   stays low (cfg writes are still taken)
// stall: a held result sits in the output register while the queue keeps
//   taking commands until it is full; the back end waits only when it has its next result ready
module first_fit_free_list_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  // apb-style config port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ffa_pkg::CFG_AW-1:0]          cfg_paddr,
  input  logic [ffa_pkg::CFG_DW-1:0]          cfg_pwdata,
  output logic [ffa_pkg::CFG_DW-1:0]          cfg_prdata,
  output logic                                cfg_pready,
  // command stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ffa_pkg::IN_TDATA_W-1:0]      in_tdata,   // pointer[31:0], request_size[47:32]
  input  logic [ffa_pkg::FUNC_W-1:0]          in_tuser,   // func[1:0]
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ffa_pkg::OUT_TDATA_W-1:0]     out_tdata,  // address[31:0], copy_length[48:32], zero pad
  output logic [ffa_pkg::STAT_W-1:0]          out_tuser   // status[1:0]
);
  import ffa_pkg::*;

  logic [PTR_W-1:0] heap_base_r;
  logic             cfg_wr;
  logic [CFG_IDXW-1:0] cfg_idx;

  cmd_t  push_cmd;
  logic  push_valid;
  logic  push_ready;
  cmd_t  q_cmd;
  logic  q_valid;
  logic  q_pop;
  logic  clearing;

  logic [STAT_W-1:0] res_status;
  logic [PTR_W-1:0]  res_address;
  logic [SIZE_W-1:0] res_copy;

  // config register, single word
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_idx == REG_HEAP_BASE) ? heap_base_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
    end else if (cfg_wr && cfg_idx == REG_HEAP_BASE) begin
      heap_base_r <= cfg_pwdata;
    end
  end

  // classify commands as they arrive
  ffa_front u_front (
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_user    (in_tuser),
    .heap_base  (heap_base_r),
    .enable     (!clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decouples the front end from the header walk
  ffa_cmd_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (push_valid),
    .s_ready (push_ready),
    .s_cmd   (push_cmd),
    .m_valid (q_valid),
    .m_ready (q_pop),
    .m_cmd   (q_cmd)
  );

  // header memory, free list walk, bump allocation and result register
  ffa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .heap_base   (heap_base_r),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_cmd),
    .clearing    (clearing),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (res_status),
    .out_address (res_address),
    .out_copy    (res_copy)
  );

  assign out_tuser = res_status;
  assign out_tdata = {(OUT_TDATA_W - SIZE_W - PTR_W)'(0), res_copy, res_address};

endmodule
